FILE: hw/rtl/gdfw_pkg.sv
// Shared types and constants for the depth-first graph walker.
package gdfw_pkg;

   localparam int VERT_W  = 6;
   localparam int COUNT_W = 7;
   localparam int MASK_W  = 64;

   localparam logic [1:0] MODE_ADD       = 2'd0;
   localparam logic [1:0] MODE_WALK_ZERO = 2'd1;
   localparam logic [1:0] MODE_WALK_ALL  = 2'd2;

   localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_ADD_LINK,
      ST_ROOT,
      ST_PUSH,
      ST_STEP,
      ST_POP,
      ST_EDGE,
      ST_EM_RD,
      ST_EM_LD
   } state_type;

endpackage

FILE: hw/rtl/gdfw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gdfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/graph_depth_first_walk.sv
// Directed-graph store with a depth-first walker that reports preorder and back-edge vertices.
// An add-edge transaction reads the list ends, then writes the edge and the list ends;
// when it extends a non-empty list it then chains the new edge behind the old tail. The
// list ends, edge pool, walk stack and preorder buffer each sit in a registered-read RAM.
// A walk holds the input while it tries root candidates, examines edges, pushes and pops
// vertices, and while it emits one result per visited vertex (order buffer read, then
// output register). All results of a walk carry the cycle mask as it stands when the
// walk has finished. Mode 3, out-of-range edges and walks with a vertex count of zero
// are absorbed without a result.
module graph_depth_first_walk
   import gdfw_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [VERT_W-1:0]  req_from_vertex,
   input  logic [VERT_W-1:0]  req_to_vertex,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VERT_W-1:0]  rsp_visited_vertex,
   output logic               rsp_last_of_walk,
   output logic [MASK_W-1:0]  rsp_cycle_nodes,
   output logic               rsp_edge_overflow
);

   localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int LW  = $clog2(MAX_EDGES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam logic [COUNT_W-1:0] VMAX      = COUNT_W'(MAX_VERTICES);
   localparam logic [LW-1:0]      NULL_LINK = LW'(MAX_EDGES);

   state_type state_ff, state_in;
   logic [COUNT_W-1:0] vc_ff, vc_in;
   logic [COUNT_W-1:0] live_n;
   logic               walk0_ff, walk0_in;
   logic [VW-1:0]      u_ff, u_in, v_ff, v_in;
   logic [LW-1:0]      eu_ff, eu_in;
   logic [LW-1:0]      tail_ff, tail_in;
   logic               ovf_ff, ovf_in;
   logic [MASK_W-1:0]  cyc_ff, cyc_in;
   logic [MAX_VERTICES-1:0] hv_ff, hv_in, onstack_ff, onstack_in, done_ff, done_in;
   logic [VW:0]        r_ff, r_in, sp_ff, sp_in, cnt_ff, cnt_in, idx_ff, idx_in;
   logic [VW-1:0]      pv_ff, pv_in, top_v_ff, top_v_in;
   logic [LW-1:0]      top_c_ff, top_c_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VERT_W-1:0]  rsp_vertex_ff, rsp_vertex_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [MASK_W-1:0]  rsp_cyc_ff, rsp_cyc_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   // list ends: {head, tail}
   logic              ht_we;
   logic [VW-1:0]     ht_wa, ht_ra;
   logic [2*LW-1:0]   ht_wd, ht_rd;
   logic [LW-1:0]     ht_head, ht_tail;
   // edge pool
   logic              tg_we, lk_we;
   logic [EAW-1:0]    tg_wa, lk_wa, eg_ra;
   logic [VW-1:0]     tg_wd, tg_rd;
   logic [LW-1:0]     lk_wd, lk_rd;
   // walk stack, lower frames only; the top frame is held in registers
   logic              st_we;
   logic [VW-1:0]     st_wa, st_ra;
   logic [VW+LW-1:0]  st_wd, st_rd;
   // preorder buffer
   logic              od_we;
   logic [VW-1:0]     od_wa, od_ra;
   logic [VW-1:0]     od_rd;
   logic              emit_last;

   assign live_n  = (vc_ff > VMAX) ? VMAX : vc_ff;
   assign ht_head = ht_rd[2*LW-1:LW];
   assign ht_tail = ht_rd[LW-1:0];
   assign od_ra   = idx_ff[VW-1:0];
   assign emit_last = ((idx_ff + 1'b1) == cnt_ff);

   gdfw_ram #(.WIDTH(2*LW), .DEPTH(MAX_VERTICES)) u_ht_ram (
      .clock(clock), .wr_en(ht_we), .wr_addr(ht_wa), .wr_data(ht_wd),
      .rd_addr(ht_ra), .rd_data(ht_rd)
   );
   gdfw_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_tg_ram (
      .clock(clock), .wr_en(tg_we), .wr_addr(tg_wa), .wr_data(tg_wd),
      .rd_addr(eg_ra), .rd_data(tg_rd)
   );
   gdfw_ram #(.WIDTH(LW), .DEPTH(MAX_EDGES)) u_lk_ram (
      .clock(clock), .wr_en(lk_we), .wr_addr(lk_wa), .wr_data(lk_wd),
      .rd_addr(eg_ra), .rd_data(lk_rd)
   );
   gdfw_ram #(.WIDTH(VW+LW), .DEPTH(MAX_VERTICES)) u_st_ram (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd)
   );
   gdfw_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_od_ram (
      .clock(clock), .wr_en(od_we), .wr_addr(od_wa), .wr_data(pv_ff),
      .rd_addr(od_ra), .rd_data(od_rd)
   );

   always_comb begin
      state_in   = state_ff;
      vc_in      = csr_wr_en ? csr_wr_data : vc_ff;
      walk0_in   = walk0_ff;
      u_in       = u_ff;
      v_in       = v_ff;
      eu_in      = eu_ff;
      tail_in    = tail_ff;
      ovf_in     = ovf_ff;
      cyc_in     = cyc_ff;
      hv_in      = hv_ff;
      onstack_in = onstack_ff;
      done_in    = done_ff;
      r_in       = r_ff;
      sp_in      = sp_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      pv_in      = pv_ff;
      top_v_in   = top_v_ff;
      top_c_in   = top_c_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_cyc_in    = rsp_cyc_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      ht_we = 1'b0;
      ht_wa = u_ff;
      ht_wd = {eu_ff, eu_ff};
      ht_ra = pv_ff;
      tg_we = 1'b0;
      tg_wa = eu_ff[EAW-1:0];
      tg_wd = v_ff;
      lk_we = 1'b0;
      lk_wa = eu_ff[EAW-1:0];
      lk_wd = NULL_LINK;
      eg_ra = top_c_ff[EAW-1:0];
      st_we = 1'b0;
      st_wa = sp_ff[VW-1:0] - 1'b1;
      st_wd = {top_v_ff, top_c_ff};
      st_ra = sp_ff[VW-1:0] - VW'(2);
      od_we = 1'b0;
      od_wa = cnt_ff[VW-1:0];

      case (state_ff)
         ST_IDLE: begin
            ht_ra = req_from_vertex[VW-1:0];
            if (req_valid) begin
               case (req_mode)
                  MODE_ADD: begin
                     if (COUNT_W'(req_from_vertex) < live_n &&
                         COUNT_W'(req_to_vertex) < live_n) begin
                        if (eu_ff == NULL_LINK) begin
                           ovf_in = 1'b1;
                        end else begin
                           u_in     = req_from_vertex[VW-1:0];
                           v_in     = req_to_vertex[VW-1:0];
                           state_in = ST_ADD_WR;
                        end
                     end
                  end
                  MODE_WALK_ZERO, MODE_WALK_ALL: begin
                     if (live_n != '0) begin
                        onstack_in = '0;
                        done_in    = '0;
                        cnt_in     = '0;
                        sp_in      = '0;
                        r_in       = '0;
                        walk0_in   = (req_mode == MODE_WALK_ZERO);
                        state_in   = ST_ROOT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD_WR: begin
            tg_we     = 1'b1;
            lk_we     = 1'b1;
            ht_we     = 1'b1;
            hv_in[u_ff] = 1'b1;
            eu_in     = eu_ff + 1'b1;
            if (!hv_ff[u_ff] || ht_head >= NULL_LINK) begin
               ht_wd    = {eu_ff, eu_ff};
               state_in = ST_IDLE;
            end else begin
               ht_wd   = {ht_head, eu_ff};
               tail_in = ht_tail;
               state_in = (ht_tail < NULL_LINK) ? ST_ADD_LINK : ST_IDLE;
            end
         end
         ST_ADD_LINK: begin
            // chain the new edge behind the old tail
            lk_we    = 1'b1;
            lk_wa    = tail_ff[EAW-1:0];
            lk_wd    = eu_ff - 1'b1;
            state_in = ST_IDLE;
         end
         ST_ROOT: begin
            ht_ra = r_ff[VW-1:0];
            if ((walk0_ff && r_ff != '0) || COUNT_W'(r_ff) >= live_n) begin
               idx_in   = '0;
               state_in = ST_EM_RD;
            end else if (onstack_ff[r_ff[VW-1:0]] || done_ff[r_ff[VW-1:0]]) begin
               r_in = r_ff + 1'b1;
            end else begin
               pv_in    = r_ff[VW-1:0];
               r_in     = r_ff + 1'b1;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (sp_ff != '0) begin
               st_we = 1'b1;
            end
            top_v_in = pv_ff;
            top_c_in = hv_ff[pv_ff] ? ht_head : NULL_LINK;
            sp_in    = sp_ff + 1'b1;
            onstack_in[pv_ff] = 1'b1;
            od_we    = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (top_c_ff >= NULL_LINK) begin
               done_in[top_v_ff] = 1'b1;
               sp_in = sp_ff - 1'b1;
               state_in = (sp_ff == (VW+1)'(1)) ? ST_ROOT : ST_POP;
            end else begin
               state_in = ST_EDGE;
            end
         end
         ST_POP: begin
            top_v_in = st_rd[VW+LW-1:LW];
            top_c_in = st_rd[LW-1:0];
            state_in = ST_STEP;
         end
         ST_EDGE: begin
            ht_ra    = tg_rd;
            top_c_in = lk_rd;
            state_in = ST_STEP;
            if (COUNT_W'(tg_rd) < live_n) begin
               if (!onstack_ff[tg_rd]) begin
                  if (COUNT_W'(sp_ff) < VMAX) begin
                     pv_in    = tg_rd;
                     state_in = ST_PUSH;
                  end
               end else if (!done_ff[tg_rd]) begin
                  cyc_in[tg_rd] = 1'b1;
               end
            end
         end
         ST_EM_RD: begin
            state_in = ST_EM_LD;
         end
         ST_EM_LD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = VERT_W'(od_rd);
               rsp_last_in   = emit_last;
               rsp_cyc_in    = cyc_ff;
               rsp_ovf_in    = ovf_ff;
               idx_in        = idx_ff + 1'b1;
               state_in      = emit_last ? ST_IDLE : ST_EM_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vc_ff        <= VCOUNT_RESET;
         eu_ff        <= '0;
         ovf_ff       <= 1'b0;
         cyc_ff       <= '0;
         hv_ff        <= '0;
         onstack_ff   <= '0;
         done_ff      <= '0;
         sp_ff        <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vc_ff        <= vc_in;
         eu_ff        <= eu_in;
         ovf_ff       <= ovf_in;
         cyc_ff       <= cyc_in;
         hv_ff        <= hv_in;
         onstack_ff   <= onstack_in;
         done_ff      <= done_in;
         sp_ff        <= sp_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk0_ff      <= walk0_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      tail_ff       <= tail_in;
      r_ff          <= r_in;
      pv_ff         <= pv_in;
      top_v_ff      <= top_v_in;
      top_c_ff      <= top_c_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_cyc_ff    <= rsp_cyc_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_visited_vertex = rsp_vertex_ff;
   assign rsp_last_of_walk   = rsp_last_ff;
   assign rsp_cycle_nodes    = rsp_cyc_ff;
   assign rsp_edge_overflow  = rsp_ovf_ff;

   // a finished vertex must have been pushed earlier in the same walk
   assert property (@(posedge clock) disable iff (reset) (done_ff & ~onstack_ff) == '0)
      else $error("finished vertex never pushed");

   assert property (@(posedge clock) disable iff (reset)
      COUNT_W'(sp_ff) <= VMAX && COUNT_W'(cnt_ff) <= VMAX)
      else $error("walk stack or preorder count out of range");

   assert property (@(posedge clock) disable iff (reset) eu_ff <= NULL_LINK)
      else $error("edge pool count out of range");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EM_LD |-> cnt_ff != '0 && idx_ff < cnt_ff)
      else $error("emit past end of preorder buffer");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_EM_LD) |=> $stable(cyc_ff) || state_ff == ST_EDGE ||
      $past(state_ff) == ST_EDGE)
      else $error("cycle mask changed outside edge check");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the depth-first graph walker.
module tb;
   import gdfw_pkg::*;

   localparam int NV = 64;
   localparam int NE = 256;
   localparam int NULL_LINK = NE;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam logic [1:0] MODE_RESERVED = 2'd3;

   typedef struct packed {
      logic [1:0]        mode;
      logic [VERT_W-1:0] from_v;
      logic [VERT_W-1:0] to_v;
   } edge_req_type;

   typedef struct packed {
      logic [VERT_W-1:0] vertex;
      logic              last;
      logic [MASK_W-1:0] mask;
      logic              ovf;
   } visit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = '0;
   logic [VERT_W-1:0] req_from_vertex = '0;
   logic [VERT_W-1:0] req_to_vertex = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [VERT_W-1:0] rsp_visited_vertex;
   logic rsp_last_of_walk;
   logic [MASK_W-1:0] rsp_cycle_nodes;
   logic rsp_edge_overflow;

   graph_depth_first_walk i_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_from_vertex(req_from_vertex), .req_to_vertex(req_to_vertex),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_visited_vertex(rsp_visited_vertex), .rsp_last_of_walk(rsp_last_of_walk),
      .rsp_cycle_nodes(rsp_cycle_nodes), .rsp_edge_overflow(rsp_edge_overflow)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // predictor state
   int unsigned vcount;
   int unsigned e_target [NE];
   int unsigned e_link [NE];
   int unsigned l_head [NV];
   int unsigned l_tail [NV];
   int unsigned used_edges;
   logic [1:0] mark [NV];
   int unsigned stk_v [NV];
   int unsigned stk_c [NV];
   logic [MASK_W-1:0] cyc_mask;
   logic ovf_seen;

   edge_req_type pending_reqs [$];
   visit_type expected_visits [$];
   int errors = 0;
   int visits_checked = 0;
   bit quiet_side = 1'b0;
   int idle_cycles = 0;
   logic req_stall_ff = 1'b0;

   task automatic graph_reset();
      vcount = 64;
      for (int i = 0; i < NV; i++) begin
         l_head[i] = NULL_LINK;
         l_tail[i] = NULL_LINK;
      end
      used_edges = 0;
      cyc_mask = '0;
      ovf_seen = 1'b0;
   endtask

   task automatic store_edge(int unsigned u, int unsigned v);
      int unsigned n;
      int unsigned e;
      n = (vcount > NV) ? NV : vcount;
      if (u >= n || v >= n) return;
      if (used_edges >= NE) begin
         ovf_seen = 1'b1;
         return;
      end
      e = used_edges;
      e_target[e] = v;
      e_link[e] = NULL_LINK;
      if (l_head[u] == NULL_LINK) l_head[u] = e;
      else if (l_tail[u] < NE) e_link[l_tail[u]] = e;
      l_tail[u] = e;
      used_edges = e + 1;
   endtask

   task automatic dfs_from(int unsigned root, int unsigned n, ref int unsigned order[$]);
      int sp;
      int unsigned e;
      int unsigned t;
      mark[root] = 2'd1;
      order.insert(order.size(), root);
      stk_v[0] = root;
      stk_c[0] = l_head[root];
      sp = 1;
      while (sp > 0) begin
         e = stk_c[sp-1];
         if (e >= NE) begin
            mark[stk_v[sp-1]] = 2'd2;
            sp--;
         end else begin
            t = e_target[e];
            stk_c[sp-1] = e_link[e];
            if (t < n) begin
               if (mark[t] == 2'd0) begin
                  if (sp < NV) begin
                     mark[t] = 2'd1;
                     order.insert(order.size(), t);
                     stk_v[sp] = t;
                     stk_c[sp] = l_head[t];
                     sp++;
                  end
               end else if (mark[t] == 2'd1) begin
                  cyc_mask[t] = 1'b1;
               end
            end
         end
      end
   endtask

   task automatic predict_request(edge_req_type r);
      int unsigned n;
      int unsigned order[$];
      visit_type x;
      n = (vcount > NV) ? NV : vcount;
      if (r.mode == MODE_ADD) begin
         store_edge(32'(r.from_v), 32'(r.to_v));
         return;
      end
      if (r.mode != MODE_WALK_ZERO && r.mode != MODE_WALK_ALL) return;
      if (n == 0) return;
      for (int i = 0; i < NV; i++) mark[i] = 2'd0;
      if (r.mode == MODE_WALK_ZERO) dfs_from(0, n, order);
      else
         for (int i = 0; i < n; i++)
            if (mark[i] == 2'd0) dfs_from(i, n, order);
      foreach (order[k]) begin
         x.vertex = VERT_W'(order[k]);
         x.last = (k == order.size() - 1);
         x.mask = cyc_mask;
         x.ovf = ovf_seen;
         expected_visits.insert(expected_visits.size(), x);
      end
   endtask

   task automatic report_mismatch(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   function automatic bit idle_now();
      return !quiet_side && ($urandom_range(99) < 27);
   endfunction

   // driver: present the head of the pending queue; predict on acceptance
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall_ff) begin
            predict_request(pending_reqs.pop_front());
         end
         if (!(req_valid && req_stall_ff)) begin
            if (pending_reqs.size() > 0 && !idle_now()) begin
               req_valid <= 1'b1;
               req_mode <= pending_reqs[0].mode;
               req_from_vertex <= pending_reqs[0].from_v;
               req_to_vertex <= pending_reqs[0].to_v;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= idle_now();
      end
   end

   // sample stall at the rising edge where acceptance is decided
   always @(posedge clock) begin
      req_stall_ff <= req_stall;
   end

   // monitor
   always @(posedge clock) begin
      visit_type x;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (expected_visits.size() == 0) begin
               report_mismatch($sformatf("unexpected visit of vertex %0d", rsp_visited_vertex));
            end else begin
               x = expected_visits.pop_front();
               visits_checked++;
               if (rsp_visited_vertex !== x.vertex)
                  report_mismatch($sformatf("vertex %0d, want %0d", rsp_visited_vertex,
                                            x.vertex));
               if (rsp_last_of_walk !== x.last)
                  report_mismatch($sformatf("last %0b, want %0b", rsp_last_of_walk, x.last));
               if (rsp_cycle_nodes !== x.mask)
                  report_mismatch($sformatf("cycle mask %h, want %h", rsp_cycle_nodes,
                                            x.mask));
               if (rsp_edge_overflow !== x.ovf)
                  report_mismatch($sformatf("overflow %0b, want %0b", rsp_edge_overflow,
                                            x.ovf));
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d visits outstanding", expected_visits.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic edge_req_type mk(logic [1:0] m, int unsigned f, int unsigned t);
      edge_req_type r;
      r.mode = m;
      r.from_v = VERT_W'(f);
      r.to_v = VERT_W'(t);
      return r;
   endfunction

   task automatic queue_req(edge_req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic push_random_phase(int items, int unsigned span);
      int unsigned p;
      for (int i = 0; i < items; i++) begin
         p = $urandom_range(99);
         if (p < 70)
            queue_req(mk(MODE_ADD, $urandom_range(span - 1), $urandom_range(span - 1)));
         else if (p < 78)
            queue_req(mk(MODE_ADD, $urandom_range(63), $urandom_range(63)));
         else if (p < 87) queue_req(mk(MODE_WALK_ZERO, $urandom, $urandom));
         else if (p < 96) queue_req(mk(MODE_WALK_ALL, $urandom, $urandom));
         else queue_req(mk(MODE_RESERVED, $urandom, $urandom));
      end
   endtask

   // wait for the block to drain, then let the tail of its work settle
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_visits.size() > 0)
         @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic set_count(int unsigned c);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= COUNT_W'(c);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      vcount = c;
   endtask

   initial begin
      graph_reset();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty walks, small cycle, self loop, cross edge, bad mode, extremes
      queue_req(mk(MODE_WALK_ZERO, 0, 0));
      queue_req(mk(MODE_ADD, 0, 1));
      queue_req(mk(MODE_ADD, 1, 2));
      queue_req(mk(MODE_ADD, 2, 0));
      queue_req(mk(MODE_ADD, 0, 2));
      queue_req(mk(MODE_ADD, 3, 3));
      queue_req(mk(MODE_ADD, 4, 1));
      queue_req(mk(MODE_ADD, 63, 63));
      queue_req(mk(MODE_ADD, 63, 0));
      queue_req(mk(MODE_RESERVED, 63, 63));
      queue_req(mk(MODE_WALK_ZERO, 63, 63));
      queue_req(mk(MODE_WALK_ALL, 0, 0));
      drain();
      set_count(5);
      queue_req(mk(MODE_ADD, 5, 0));
      queue_req(mk(MODE_ADD, 1, 4));
      queue_req(mk(MODE_WALK_ALL, 0, 0));
      queue_req(mk(MODE_WALK_ZERO, 0, 0));
      drain();
      set_count(0);
      queue_req(mk(MODE_ADD, 0, 0));
      queue_req(mk(MODE_WALK_ALL, 0, 0));
      queue_req(mk(MODE_WALK_ZERO, 0, 0));
      drain();
      set_count(127);
      queue_req(mk(MODE_WALK_ALL, 0, 0));
      drain();

      // random phases over several counts; one phase runs without idling
      set_count(8);
      push_random_phase(40, 8);
      drain();
      set_count(1);
      push_random_phase(10, 1);
      drain();
      quiet_side = 1'b1;
      set_count(64);
      push_random_phase(50, 64);
      drain();
      quiet_side = 1'b0;
      set_count($urandom_range(2, 63));
      push_random_phase(40, vcount);
      drain();
      // dense load on a small graph
      set_count(16);
      for (int i = 0; i < 40; i++)
         queue_req(mk(MODE_ADD, $urandom_range(15), $urandom_range(15)));
      queue_req(mk(MODE_WALK_ALL, 0, 0));
      queue_req(mk(MODE_WALK_ZERO, 0, 0));
      drain();
      set_count(3);
      push_random_phase(15, 3);
      drain();

      $display("Checked %0d visited vertices over vertex counts from 0 to 127,",
               visits_checked);
      $display("with %0d edges stored and overflow flag %0b", used_edges, ovf_seen);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
